[rtl/fbsd_pkg.sv]
// ----------------------------------------------------------------------------
// FAT boot sector decode package
// Field widths, valid geometry codes, FAT type codes and error bit positions
// shared by the decoder and its port checker.
// ----------------------------------------------------------------------------
package fbsd_pkg;

    // Input field widths.
    localparam int SECTOR_SIZE_W   = 16;
    localparam int CLUSTER_SECS_W  = 8;
    localparam int COUNT16_W       = 16;
    localparam int COUNT32_W       = 32;
    localparam int COPIES_W        = 8;

    // Result field widths.
    localparam int ERROR_W         = 6;
    localparam int KIND_W          = 2;
    localparam int ROOT_SECS_W     = 13;
    localparam int FIRST_DATA_W    = 33;
    localparam int FAT_OFFSET_W    = 28;
    localparam int BYTES44_W       = 44;
    localparam int BYTES48_W       = 48;

    // Internal widths.
    localparam int SSHIFT_W        = 4;
    localparam int CSHIFT_W        = 3;
    localparam int FAT_AREA_W      = 40;

    // Valid bytes-per-sector values.
    localparam logic [SECTOR_SIZE_W-1:0] SECTOR_512  = 16'd512;
    localparam logic [SECTOR_SIZE_W-1:0] SECTOR_1024 = 16'd1024;
    localparam logic [SECTOR_SIZE_W-1:0] SECTOR_2048 = 16'd2048;
    localparam logic [SECTOR_SIZE_W-1:0] SECTOR_4096 = 16'd4096;

    // Cluster count limits that pick the FAT type.
    localparam logic [COUNT32_W-1:0] FAT12_CLUSTER_LIMIT = 32'd4085;
    localparam logic [COUNT32_W-1:0] FAT16_CLUSTER_LIMIT = 32'd65525;

    // FAT type codes.
    localparam logic [KIND_W-1:0] KIND_FAT12 = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FAT16 = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FAT32 = 2'd2;

    // Error bit positions.
    localparam int ERR_SECTOR_SIZE  = 0;
    localparam int ERR_CLUSTER_SIZE = 1;
    localparam int ERR_TOTAL        = 2;
    localparam int ERR_RESERVED     = 3;
    localparam int ERR_FAT_SECTORS  = 4;
    localparam int ERR_FAT_COPIES   = 5;

    // Middle stage contents: checks done so far and the selected counts.
    typedef struct packed {
        logic [ERROR_W-2:0]      err;
        logic                    copies_zero;
        logic [COUNT32_W-1:0]    total;
        logic [COUNT32_W-1:0]    spf;
        logic [FAT_AREA_W-1:0]   fat_area;
        logic [COUNT16_W-1:0]    resv;
        logic [ROOT_SECS_W-1:0]  root_secs;
        logic [SSHIFT_W-1:0]     sshift;
        logic [CSHIFT_W-1:0]     cshift;
        logic [COUNT32_W-1:0]    rclust;
    } mid_t;

    // One decoded result item.
    typedef struct packed {
        logic [ERROR_W-1:0]      error_bits;
        logic [KIND_W-1:0]       fat_kind;
        logic [COUNT32_W-1:0]    cluster_total;
        logic [ROOT_SECS_W-1:0]  root_dir_sector_count;
        logic [FIRST_DATA_W-1:0] data_first_sector;
        logic [COUNT32_W-1:0]    data_sector_total;
        logic [FAT_OFFSET_W-1:0] fat_offset_bytes;
        logic [BYTES44_W-1:0]    fat_size_bytes;
        logic [BYTES48_W-1:0]    root_offset_bytes;
        logic [BYTES48_W-1:0]    data_offset_bytes;
        logic [BYTES44_W-1:0]    volume_bytes;
        logic [BYTES44_W-1:0]    data_region_bytes;
    } res_t;

endpackage

[rtl/fat_boot_sector_decode_top.sv]
// ----------------------------------------------------------------------------
// FAT boot sector decode
// Checks the geometry fields of a FAT boot sector and derives the volume
// layout in a three-register pipeline.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while s_ready is high and passes it
// through an input register, a middle register after the field checks and the
// FAT-size multiply, and the result register after the layout arithmetic. Each
// stage advances when the next one is empty or moving, so a stalled result holds
// the pipeline while s_ready falls only once every stage is full. With any error
// bit set, all layout fields of the result are zero. There is no configuration
// and no state between items.
module fat_boot_sector_decode_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [fbsd_pkg::SECTOR_SIZE_W-1:0]   s_sector_size_field,
    input  logic [fbsd_pkg::CLUSTER_SECS_W-1:0]  s_cluster_sectors_field,
    input  logic [fbsd_pkg::COUNT16_W-1:0]       s_total_sectors_short,
    input  logic [fbsd_pkg::COUNT32_W-1:0]       s_total_sectors_long,
    input  logic [fbsd_pkg::COUNT16_W-1:0]       s_reserved_sector_count,
    input  logic [fbsd_pkg::COUNT16_W-1:0]       s_fat_sectors_short,
    input  logic [fbsd_pkg::COUNT32_W-1:0]       s_fat_sectors_long,
    input  logic [fbsd_pkg::COPIES_W-1:0]        s_fat_copies,
    input  logic [fbsd_pkg::COUNT16_W-1:0]       s_root_entry_count,
    input  logic [fbsd_pkg::COUNT32_W-1:0]       s_root_start_cluster,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [fbsd_pkg::ERROR_W-1:0]         m_error_bits,
    output logic [fbsd_pkg::KIND_W-1:0]          m_fat_kind,
    output logic [fbsd_pkg::COUNT32_W-1:0]       m_cluster_total,
    output logic [fbsd_pkg::ROOT_SECS_W-1:0]     m_root_dir_sector_count,
    output logic [fbsd_pkg::FIRST_DATA_W-1:0]    m_data_first_sector,
    output logic [fbsd_pkg::COUNT32_W-1:0]       m_data_sector_total,
    output logic [fbsd_pkg::FAT_OFFSET_W-1:0]    m_fat_offset_bytes,
    output logic [fbsd_pkg::BYTES44_W-1:0]       m_fat_size_bytes,
    output logic [fbsd_pkg::BYTES48_W-1:0]       m_root_offset_bytes,
    output logic [fbsd_pkg::BYTES48_W-1:0]       m_data_offset_bytes,
    output logic [fbsd_pkg::BYTES44_W-1:0]       m_volume_bytes,
    output logic [fbsd_pkg::BYTES44_W-1:0]       m_data_region_bytes
);
    import fbsd_pkg::*;

    // Pipeline control.
    logic a_valid_reg;
    logic b_valid_reg;
    logic c_valid_reg;
    logic b_ready;
    logic c_ready;

    // Input stage registers.
    logic [SECTOR_SIZE_W-1:0]  ssize_reg;
    logic [CLUSTER_SECS_W-1:0] csize_reg;
    logic [COUNT16_W-1:0]      ts16_reg;
    logic [COUNT32_W-1:0]      ts32_reg;
    logic [COUNT16_W-1:0]      resv_reg;
    logic [COUNT16_W-1:0]      spf16_reg;
    logic [COUNT32_W-1:0]      spf32_reg;
    logic [COPIES_W-1:0]       copies_reg;
    logic [COUNT16_W-1:0]      nroot_reg;
    logic [COUNT32_W-1:0]      rclust_reg;

    // Middle and result stages.
    mid_t mid_reg;
    mid_t mid_next;
    res_t res_reg;
    res_t res_next;

    // Stage one signals.
    logic [21:0] root_bytes_round;
    logic [21:0] root_secs_full;

    // Stage two signals.
    logic                    err_copies;
    logic [ERROR_W-1:0]      err_all;
    logic [COUNT32_W-1:0]    fa32;
    logic [33:0]             first_data;
    logic                    underflow;
    logic [COUNT32_W-1:0]    data_secs;
    logic [COUNT32_W-1:0]    clusters;
    logic [KIND_W-1:0]       kind;
    logic [FAT_OFFSET_W-1:0] fat_off;
    logic [BYTES44_W-1:0]    fat_size;
    logic [BYTES44_W-1:0]    fats_bytes;
    logic [44:0]             meta_bytes;
    logic [BYTES48_W-1:0]    root_sec_bytes;
    logic [COUNT32_W-1:0]    root_clust;
    logic [FAT_AREA_W-1:0]   clust_secs;
    logic [40:0]             root_sector;
    logic [51:0]             root_byte_full;
    logic [BYTES48_W-1:0]    root_off_fat32;
    logic [BYTES48_W-1:0]    root_off_legacy;

    // Each stage moves on when the stage after it is empty or moving.
    assign c_ready = !c_valid_reg || m_ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign s_ready = !a_valid_reg || b_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                a_valid_reg <= s_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    // Capture an accepted input item.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ssize_reg  <= s_sector_size_field;
            csize_reg  <= s_cluster_sectors_field;
            ts16_reg   <= s_total_sectors_short;
            ts32_reg   <= s_total_sectors_long;
            resv_reg   <= s_reserved_sector_count;
            spf16_reg  <= s_fat_sectors_short;
            spf32_reg  <= s_fat_sectors_long;
            copies_reg <= s_fat_copies;
            nroot_reg  <= s_root_entry_count;
            rclust_reg <= s_root_start_cluster;
        end
    end

    // Stage one: field checks, count selection, FAT area product and the
    // root directory size in sectors.
    assign root_bytes_round = {1'b0, nroot_reg, 5'b0} + {6'b0, ssize_reg} - 22'd1;

    always_comb begin
        mid_next = '0;

        // Sector size must be one of the four legal values.
        unique case (ssize_reg)
            SECTOR_512:  mid_next.sshift = 4'd9;
            SECTOR_1024: mid_next.sshift = 4'd10;
            SECTOR_2048: mid_next.sshift = 4'd11;
            SECTOR_4096: mid_next.sshift = 4'd12;
            default: begin
                mid_next.sshift = 4'd9;
                mid_next.err[ERR_SECTOR_SIZE] = 1'b1;
            end
        endcase

        // Sectors per cluster must be a power of two.
        unique case (csize_reg)
            8'd1:    mid_next.cshift = 3'd0;
            8'd2:    mid_next.cshift = 3'd1;
            8'd4:    mid_next.cshift = 3'd2;
            8'd8:    mid_next.cshift = 3'd3;
            8'd16:   mid_next.cshift = 3'd4;
            8'd32:   mid_next.cshift = 3'd5;
            8'd64:   mid_next.cshift = 3'd6;
            8'd128:  mid_next.cshift = 3'd7;
            default: begin
                mid_next.cshift = 3'd0;
                mid_next.err[ERR_CLUSTER_SIZE] = 1'b1;
            end
        endcase

        // The short counts win when they are nonzero.
        mid_next.total = (ts16_reg != '0) ? {16'b0, ts16_reg} : ts32_reg;
        mid_next.spf   = (spf16_reg != '0) ? {16'b0, spf16_reg} : spf32_reg;

        mid_next.err[ERR_TOTAL] = (mid_next.total == '0);
        mid_next.err[ERR_RESERVED] = !mid_next.err[ERR_TOTAL]
                                     && ({16'b0, resv_reg} > mid_next.total);
        mid_next.err[ERR_FAT_SECTORS] = (mid_next.spf == '0)
                                        || (!mid_next.err[ERR_TOTAL]
                                            && (mid_next.spf > mid_next.total));

        root_secs_full = root_bytes_round >> mid_next.sshift;

        mid_next.copies_zero = (copies_reg == '0);
        mid_next.fat_area    = {32'b0, copies_reg} * {8'b0, mid_next.spf};
        mid_next.resv        = resv_reg;
        mid_next.root_secs   = root_secs_full[ROOT_SECS_W-1:0];
        mid_next.rclust      = rclust_reg;
    end

    always_ff @(posedge aclk) begin
        if (b_ready) begin
            mid_reg <= mid_next;
        end
    end

    // Stage two: the copies check and the volume layout. With no error the
    // FAT area fits in 32 bits, so the layout uses its low word.
    assign err_copies = mid_reg.copies_zero
                        || (!mid_reg.err[ERR_TOTAL] && !mid_reg.err[ERR_FAT_SECTORS]
                            && (mid_reg.fat_area > {8'b0, mid_reg.total}));
    assign err_all    = {err_copies, mid_reg.err};
    assign fa32       = mid_reg.fat_area[COUNT32_W-1:0];

    // Data region in sectors, saturating at zero.
    assign first_data = {18'b0, mid_reg.resv} + {2'b0, fa32} + {21'b0, mid_reg.root_secs};
    assign underflow  = ({2'b0, mid_reg.total} <= first_data);
    assign data_secs  = underflow ? '0 : (mid_reg.total - first_data[COUNT32_W-1:0]);
    assign clusters   = data_secs >> mid_reg.cshift;

    // FAT type by cluster count.
    always_comb begin
        priority if (clusters < FAT12_CLUSTER_LIMIT) begin
            kind = KIND_FAT12;
        end else if (clusters < FAT16_CLUSTER_LIMIT) begin
            kind = KIND_FAT16;
        end else begin
            kind = KIND_FAT32;
        end
    end

    // Byte offsets and sizes.
    assign fat_off        = {12'b0, mid_reg.resv} << mid_reg.sshift;
    assign fat_size       = {12'b0, mid_reg.spf} << mid_reg.sshift;
    assign fats_bytes     = {12'b0, fa32} << mid_reg.sshift;
    assign meta_bytes     = {17'b0, fat_off} + {1'b0, fats_bytes};
    assign root_sec_bytes = {35'b0, mid_reg.root_secs} << mid_reg.sshift;
    assign root_off_legacy = {3'b0, meta_bytes};

    // FAT32 root directory: cluster number to byte offset, saturated.
    assign root_clust     = (mid_reg.rclust >= 32'd2) ? (mid_reg.rclust - 32'd2) : '0;
    assign clust_secs     = {8'b0, root_clust} << mid_reg.cshift;
    assign root_sector    = {1'b0, clust_secs} + {7'b0, first_data};
    assign root_byte_full = {11'b0, root_sector} << mid_reg.sshift;
    assign root_off_fat32 = (root_byte_full[51:48] != '0) ? '1
                                                          : root_byte_full[BYTES48_W-1:0];

    always_comb begin
        res_next = '0;
        res_next.error_bits = err_all;
        if (err_all == '0) begin
            res_next.fat_kind              = kind;
            res_next.cluster_total         = clusters;
            res_next.root_dir_sector_count = mid_reg.root_secs;
            res_next.data_first_sector     = first_data[FIRST_DATA_W-1:0];
            res_next.data_sector_total     = data_secs;
            res_next.fat_offset_bytes      = fat_off;
            res_next.fat_size_bytes        = fat_size;
            res_next.volume_bytes          = {12'b0, mid_reg.total} << mid_reg.sshift;
            res_next.data_region_bytes     = {12'b0, data_secs} << mid_reg.sshift;
            if (kind == KIND_FAT32) begin
                res_next.root_offset_bytes = root_off_fat32;
                res_next.data_offset_bytes = root_off_legacy;
            end else begin
                res_next.root_offset_bytes = root_off_legacy;
                res_next.data_offset_bytes = root_off_legacy + root_sec_bytes;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (c_ready) begin
            res_reg <= res_next;
        end
    end

    // Result ports.
    assign m_valid                 = c_valid_reg;
    assign m_error_bits            = res_reg.error_bits;
    assign m_fat_kind              = res_reg.fat_kind;
    assign m_cluster_total         = res_reg.cluster_total;
    assign m_root_dir_sector_count = res_reg.root_dir_sector_count;
    assign m_data_first_sector     = res_reg.data_first_sector;
    assign m_data_sector_total     = res_reg.data_sector_total;
    assign m_fat_offset_bytes      = res_reg.fat_offset_bytes;
    assign m_fat_size_bytes        = res_reg.fat_size_bytes;
    assign m_root_offset_bytes     = res_reg.root_offset_bytes;
    assign m_data_offset_bytes     = res_reg.data_offset_bytes;
    assign m_volume_bytes          = res_reg.volume_bytes;
    assign m_data_region_bytes     = res_reg.data_region_bytes;

endmodule

[rtl/fbsd_checker.sv]
// ----------------------------------------------------------------------------
// FAT boot sector decode port checker
// Watches the decoder's ports and flags results or handshakes that cannot
// come from a correct decode.
// ----------------------------------------------------------------------------
module fbsd_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic [fbsd_pkg::SECTOR_SIZE_W-1:0]   s_sector_size_field,
    input  logic [fbsd_pkg::CLUSTER_SECS_W-1:0]  s_cluster_sectors_field,
    input  logic [fbsd_pkg::COUNT16_W-1:0]       s_total_sectors_short,
    input  logic [fbsd_pkg::COUNT32_W-1:0]       s_total_sectors_long,
    input  logic [fbsd_pkg::COUNT16_W-1:0]       s_reserved_sector_count,
    input  logic [fbsd_pkg::COUNT16_W-1:0]       s_fat_sectors_short,
    input  logic [fbsd_pkg::COUNT32_W-1:0]       s_fat_sectors_long,
    input  logic [fbsd_pkg::COPIES_W-1:0]        s_fat_copies,
    input  logic [fbsd_pkg::COUNT16_W-1:0]       s_root_entry_count,
    input  logic [fbsd_pkg::COUNT32_W-1:0]       s_root_start_cluster,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic [fbsd_pkg::ERROR_W-1:0]         m_error_bits,
    input  logic [fbsd_pkg::KIND_W-1:0]          m_fat_kind,
    input  logic [fbsd_pkg::COUNT32_W-1:0]       m_cluster_total,
    input  logic [fbsd_pkg::ROOT_SECS_W-1:0]     m_root_dir_sector_count,
    input  logic [fbsd_pkg::FIRST_DATA_W-1:0]    m_data_first_sector,
    input  logic [fbsd_pkg::COUNT32_W-1:0]       m_data_sector_total,
    input  logic [fbsd_pkg::FAT_OFFSET_W-1:0]    m_fat_offset_bytes,
    input  logic [fbsd_pkg::BYTES44_W-1:0]       m_fat_size_bytes,
    input  logic [fbsd_pkg::BYTES48_W-1:0]       m_root_offset_bytes,
    input  logic [fbsd_pkg::BYTES48_W-1:0]       m_data_offset_bytes,
    input  logic [fbsd_pkg::BYTES44_W-1:0]       m_volume_bytes,
    input  logic [fbsd_pkg::BYTES44_W-1:0]       m_data_region_bytes
);
    import fbsd_pkg::*;

    // A stalled result item holds its values.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_error_bits)
            && $stable(m_cluster_total) && $stable(m_root_offset_bytes))
        else $error("stalled result item changed");

    // A result item with an error carries no layout.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_error_bits != '0) |-> (m_fat_kind == KIND_FAT12)
            && (m_cluster_total == '0) && (m_root_dir_sector_count == '0)
            && (m_data_first_sector == '0) && (m_data_sector_total == '0)
            && (m_fat_offset_bytes == '0) && (m_fat_size_bytes == '0)
            && (m_root_offset_bytes == '0) && (m_data_offset_bytes == '0)
            && (m_volume_bytes == '0) && (m_data_region_bytes == '0))
        else $error("error result item carries layout values");

    // The FAT type follows the cluster count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_fat_kind == KIND_FAT32) == (m_cluster_total >= FAT16_CLUSTER_LIMIT))
            && ((m_fat_kind == KIND_FAT12) == (m_cluster_total < FAT12_CLUSTER_LIMIT)))
        else $error("FAT type disagrees with cluster count");

    // With no result pending the pipeline cannot be full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while no result item is pending");

    // A valid item never leaves reset.
    assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result item valid right after reset");

endmodule

bind fat_boot_sector_decode_top fbsd_checker u_fbsd_checker (.*);
